// File: rtl/fctm_pkg.sv
// ----------------------------------------------------------------------------
// fctm_pkg
// Shared types and constants for the floor/ceiling texel mapper.
// ----------------------------------------------------------------------------
package fctm_pkg;

  // default geometry
  localparam int DEF_SCREEN_WIDTH  = 1024;
  localparam int DEF_SCREEN_HEIGHT = 1024;
  localparam int DEF_TEX_WIDTH     = 64;
  localparam int DEF_TEX_HEIGHT    = 64;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_X       = 3'd0,
    CFG_CAM_Y       = 3'd1,
    CFG_LEFT_RAY_X  = 3'd2,
    CFG_LEFT_RAY_Y  = 3'd3,
    CFG_PLANE_X     = 3'd4,
    CFG_PLANE_Y     = 3'd5,
    CFG_HORIZON_ROW = 3'd6,
    CFG_EYE_Z       = 3'd7
  } cfg_reg_t;

  // payload widths
  localparam int ROW_W       = 10;
  localparam int EYE_W       = 11;
  localparam int RAY_W       = 16;
  localparam int POS_W       = 32;
  localparam int TEX_COORD_W = 6;
  localparam int TEXEL_IDX_W = 12;
  localparam logic [ROW_W-1:0] HORIZON_RST = 10'd512;

  // eye height z = H/2 +/- eye_z needs 13 bits signed for any legal H
  localparam int Z_W = 13;

  // divider: |z| << 16 over |row - horizon|
  localparam int DIV_DVD_W = Z_W - 1 + 16;
  localparam int DIV_DVS_W = ROW_W;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/fctm_div.sv
// ----------------------------------------------------------------------------
// fctm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fctm_div
  import fctm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_DVD_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_DVS_W-1:0] rem_r;
  logic [DIV_DVS_W-1:0] dvs_r;
  logic [DIV_DVD_W-1:0] quo_r;

  logic [DIV_DVS_W:0]   trial;
  logic [DIV_DVS_W:0]   diff;
  logic                 q_bit;

  assign trial = {rem_r, quo_r[DIV_DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  // borrow out means the trial remainder is below the divisor
  assign q_bit = ~diff[DIV_DVS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= q_bit ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
      quo_r <= {quo_r[DIV_DVD_W-2:0], q_bit};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: rtl/floor_ceiling_texel_mapper_unit.sv
// ----------------------------------------------------------------------------
// floor_ceiling_texel_mapper_unit
// Floor/ceiling casting: per-row distance, left-ray world point and pixel step,
// then texel coordinates for each pixel beat.
// ----------------------------------------------------------------------------
//  channel | ports                                        | dir
//  --------+----------------------------------------------+-----
//  input   | in_valid in_stall in_action in_row in_surface| in
//  result  | out_valid out_stall out_tex_x out_tex_y      | out
//          | out_texel_index                              |
//  config  | cfg_we cfg_index cfg_data                    | in
//
//  Row start: accept, then the divider, then the multiply/accumulate steps;
//  a row on the horizon skips the divider. No result.
//  Pixel: S_TEX then S_EMIT, plus any wait on out_stall; one result beat.
//  Row setup runs on the bit-serial divider and the single shared 32x16 multiplier.
//  in_stall is high whenever an item is in flight. Reset is synchronous.
// ----------------------------------------------------------------------------
module floor_ceiling_texel_mapper_unit
  import fctm_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int TEX_WIDTH     = DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT    = DEF_TEX_HEIGHT
)
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_action,
  input  logic [ROW_W-1:0]       in_row,
  input  logic                   in_surface,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [TEX_COORD_W-1:0] out_tex_x,
  output logic [TEX_COORD_W-1:0] out_tex_y,
  output logic [TEXEL_IDX_W-1:0] out_texel_index
);

  // floor(log2(width/2)) plus the Q2.14 scale
  localparam int STEP_SH = 14 + $clog2(SCREEN_WIDTH / 2 + 1) - 1;
  localparam logic [Z_W-1:0] HALF_H = Z_W'(SCREEN_HEIGHT / 2);

  localparam int TXW = $clog2(TEX_WIDTH);
  localparam int TYW = $clog2(TEX_HEIGHT);
  localparam int TWW = $clog2(TEX_WIDTH + 1);
  localparam int THW = $clog2(TEX_HEIGHT + 1);
  localparam int IDXW = TXW + TYW;
  localparam logic [TWW-1:0] TW_C = TWW'(TEX_WIDTH);
  localparam logic [THW-1:0] TH_C = THW'(TEX_HEIGHT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MUL  = 6'b000100,
    S_ACC  = 6'b001000,
    S_TEX  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [POS_W-1:0]        cam_x_r, cam_y_r;
  logic signed [RAY_W-1:0] left_ray_x_r, left_ray_y_r, plane_x_r, plane_y_r;
  logic [ROW_W-1:0]        horizon_r;
  logic [EYE_W-1:0]        eye_z_r;

  // row state
  logic signed [POS_W-1:0] rd_r;
  logic [POS_W-1:0]        grid_x_r, grid_y_r, step_x_r, step_y_r;
  logic                    q_neg_r;
  logic [1:0]              k_r;
  logic signed [47:0]      prod_r;

  // pixel path
  logic [15:0]             frac_x_r, frac_y_r;
  logic [TXW-1:0]          tx_r;
  logic [TYW-1:0]          ty_r;
  logic                    out_valid_r;
  logic [TEX_COORD_W-1:0]  out_tex_x_r, out_tex_y_r;
  logic [TEXEL_IDX_W-1:0]  out_idx_r;

  logic accept, out_free;
  logic row_start, pix_start;

  // row setup arithmetic
  logic signed [Z_W-1:0]   eye_ext, z;
  logic [Z_W-1:0]          z_neg;
  logic signed [ROW_W:0]   p;
  logic [Z_W-2:0]          z_mag;
  logic [ROW_W:0]          p_abs;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic signed [RAY_W-1:0] mul_op;
  logic signed [47:0]      step_sh;
  logic [POS_W-1:0]        q_ext;

  logic [16+TWW-1:0]       px_prod;
  logic [16+THW-1:0]       py_prod;
  logic [IDXW-1:0]         idx;

  assign accept    = in_valid & (state_r == S_IDLE);
  assign row_start = accept & ~in_action;
  assign pix_start = accept & in_action;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_stall  = (state_r != S_IDLE);

  // eye height and row offset from the horizon
  assign eye_ext = {{(Z_W-EYE_W){eye_z_r[EYE_W-1]}}, eye_z_r};
  assign z       = in_surface ? HALF_H + eye_ext : HALF_H - eye_ext;
  assign p       = in_surface ? {1'b0, in_row} - {1'b0, horizon_r}
                              : {1'b0, horizon_r} - {1'b0, in_row};
  assign z_neg   = -z;
  assign z_mag   = z[Z_W-1] ? z_neg[Z_W-2:0] : z[Z_W-2:0];
  assign p_abs   = p[ROW_W] ? -p : p;

  assign div_req.start    = row_start & (p != '0);
  assign div_req.dividend = {z_mag, 16'b0};
  assign div_req.divisor  = p_abs[ROW_W-1:0];

  fctm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign q_ext = {{(POS_W-DIV_DVD_W){1'b0}}, div_rsp.quotient};

  always_comb begin
    unique case (k_r)
      2'd0: mul_op = left_ray_x_r;
      2'd1: mul_op = left_ray_y_r;
      2'd2: mul_op = plane_x_r;
      2'd3: mul_op = plane_y_r;
      default: mul_op = left_ray_x_r;
    endcase
  end

  assign step_sh = prod_r >>> STEP_SH;

  // texel coordinates from the fraction bits
  assign px_prod = (16+TWW)'(frac_x_r) * (16+TWW)'(TW_C);
  assign py_prod = (16+THW)'(frac_y_r) * (16+THW)'(TH_C);
  assign idx     = IDXW'(ty_r) * IDXW'(TW_C) + IDXW'(tx_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (row_start) state_nxt = (p != '0) ? S_DIV : S_MUL;
        else if (pix_start) state_nxt = S_TEX;
      end
      S_DIV:  if (div_rsp.done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (k_r == 2'd3) ? S_IDLE : S_MUL;
      S_TEX:  state_nxt = S_EMIT;
      S_EMIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r      <= '0;
      cam_y_r      <= '0;
      left_ray_x_r <= '0;
      left_ray_y_r <= '0;
      plane_x_r    <= '0;
      plane_y_r    <= '0;
      horizon_r    <= HORIZON_RST;
      eye_z_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAM_X:       cam_x_r      <= cfg_data;
        CFG_CAM_Y:       cam_y_r      <= cfg_data;
        CFG_LEFT_RAY_X:  left_ray_x_r <= cfg_data[RAY_W-1:0];
        CFG_LEFT_RAY_Y:  left_ray_y_r <= cfg_data[RAY_W-1:0];
        CFG_PLANE_X:     plane_x_r    <= cfg_data[RAY_W-1:0];
        CFG_PLANE_Y:     plane_y_r    <= cfg_data[RAY_W-1:0];
        CFG_HORIZON_ROW: horizon_r    <= cfg_data[ROW_W-1:0];
        CFG_EYE_Z:       eye_z_r      <= cfg_data[EYE_W-1:0];
        default: ;
      endcase
    end
  end

  // row state and grid walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r     <= '0;
      grid_x_r <= '0;
      grid_y_r <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      k_r      <= '0;
      q_neg_r  <= 1'b0;
    end else begin
      if (row_start) begin
        k_r     <= '0;
        q_neg_r <= z[Z_W-1] ^ p[ROW_W];
        // on the horizon: saturate by the sign of z
        if (p == '0) rd_r <= z[Z_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      if (state_r == S_DIV && div_rsp.done) rd_r <= q_neg_r ? -q_ext : q_ext;
      if (state_r == S_ACC) begin
        k_r <= k_r + 2'd1;
        unique case (k_r)
          2'd0: grid_x_r <= cam_x_r + prod_r[45:14];
          2'd1: grid_y_r <= cam_y_r + prod_r[45:14];
          2'd2: step_x_r <= step_sh[POS_W-1:0];
          2'd3: step_y_r <= step_sh[POS_W-1:0];
          default: ;
        endcase
      end
      if (pix_start) begin
        grid_x_r <= grid_x_r + step_x_r;
        grid_y_r <= grid_y_r + step_y_r;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) prod_r <= rd_r * mul_op;
    if (pix_start) begin
      frac_x_r <= grid_x_r[15:0];
      frac_y_r <= grid_y_r[15:0];
    end
    if (state_r == S_TEX) begin
      tx_r <= px_prod[16 +: TXW];
      ty_r <= py_prod[16 +: TYW];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_tex_x_r <= TEX_COORD_W'(tx_r);
      out_tex_y_r <= TEX_COORD_W'(ty_r);
      out_idx_r   <= TEXEL_IDX_W'(idx);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tex_x       = out_tex_x_r;
  assign out_tex_y       = out_tex_y_r;
  assign out_texel_index = out_idx_r;

endmodule
